// ===== src/pipt_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Point-in-polygon test package
// Field widths and command codes shared by the point-in-polygon test unit.
// -----------------------------------------------------------------------------
package pipt_pkg;

   localparam int FIELD_WIDTH  = 32;
   localparam int INDEX_WIDTH  = 6;
   localparam int COUNT_WIDTH  = 7;
   localparam int MIN_VERTICES = 3;
   localparam int COUNT_RESET  = 3;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

endpackage

// ===== src/point_in_polygon_test_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Point-in-polygon test unit
// Vertex table written by load beats; a query beat tests a point against the
// closed polygon by ray crossing with exact integer cross products.
// -----------------------------------------------------------------------------
// A load beat writes one table slot; slots at or above MAX_VERTICES are
// dropped. n is the vertex count clamped to 3..MAX_VERTICES. The table is
// read one vertex per cycle through its single read port (n + 1 reads, the
// first vertex again to close the polygon). Each edge then passes the read
// register, the difference stage and the product stage, where two
// cross-product multipliers feed the subtract and test. The sequencer waits
// until the datapath is empty; the finish state then loads the output
// register and returns to idle, where the next beat is taken. Requests wait
// longer while a previous response beat still waits in the output
// register. The vertex count is sampled when a query beat is accepted.
// -----------------------------------------------------------------------------
module point_in_polygon_test_unit #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_WIDTH  = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_op,
   input  logic        [pipt_pkg::INDEX_WIDTH-1:0]   req_vertex_index,
   input  logic signed [pipt_pkg::FIELD_WIDTH-1:0]   req_coord_x,
   input  logic signed [pipt_pkg::FIELD_WIDTH-1:0]   req_coord_y,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_inside_res,
   output logic                                      rsp_on_boundary,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic        [pipt_pkg::COUNT_WIDTH-1:0]   csr_vertex_count
);
   import pipt_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int PW = 2 * W + 2;
   localparam int DW = 2 * W + 3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   state_type state_ff;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [CW-1:0]          n_ff;
   logic [CW-1:0]          n_in;
   logic [CW-1:0]          cnt_ff;
   logic                   iss_done_ff;
   logic                   issue;
   logic [AW-1:0]          rd_addr;

   logic                   rd_vld_ff;
   logic                   rd_first_ff;
   logic                   e_vld_ff;
   logic                   m_vld_ff;

   logic                   on_ff;
   logic                   par_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_inside_ff;
   logic                   rsp_on_ff;

   logic [2*W-1:0]         vertex_store [MAX_VERTICES];
   logic [AW-1:0]          wr_addr;
   logic                   wr_en;
   logic                   req_fire;

   logic signed [W-1:0]    px_ff, py_ff;
   logic signed [W-1:0]    rd_x_ff, rd_y_ff;
   logic signed [W-1:0]    prev_x_ff, prev_y_ff;

   logic signed [W:0]      a_ff, b_ff, c_ff, d_ff;
   logic signed [W:0]      a_in, b_in, c_in, d_in;
   logic                   bbox_in, straddle_in, dxpos_in;
   logic                   bbox_ff, straddle_ff, dxpos_ff;

   logic signed [PW-1:0]   p1_ff, p2_ff;
   logic signed [PW-1:0]   p1_in, p2_in;
   logic                   m_bbox_ff, m_straddle_ff, m_dxpos_ff;

   logic signed [DW-1:0]   cross_diff;
   logic                   cross_zero;
   logic                   cross_pos;
   logic                   hit_on;
   logic                   hit_cross;

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inside_res  = rsp_inside_ff;
   assign rsp_on_boundary = rsp_on_ff;

   assign req_fire = req_valid && req_ready;
   assign wr_addr  = AW'(req_vertex_index);
   assign wr_en    = req_fire && (req_op == OP_LOAD) &&
                     (int'(req_vertex_index) < MAX_VERTICES);

   always_comb begin
      if (int'(count_ff) < MIN_VERTICES) begin
         n_in = CW'(MIN_VERTICES);
      end else if (int'(count_ff) > MAX_VERTICES) begin
         n_in = CW'(MAX_VERTICES);
      end else begin
         n_in = CW'(count_ff);
      end
   end

   assign issue   = (state_ff == ST_RUN) && !iss_done_ff;
   assign rd_addr = (cnt_ff == n_ff) ? '0 : cnt_ff[AW-1:0];

   // vertex table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vertex_store[wr_addr] <= {req_coord_y[W-1:0], req_coord_x[W-1:0]};
      end
      rd_x_ff <= vertex_store[rd_addr][W-1:0];
      rd_y_ff <= vertex_store[rd_addr][2*W-1:W];
   end

   // edge differences and bounding-box tests
   always_comb begin
      a_in        = {px_ff[W-1], px_ff} - {prev_x_ff[W-1], prev_x_ff};
      b_in        = {rd_y_ff[W-1], rd_y_ff} - {prev_y_ff[W-1], prev_y_ff};
      c_in        = {py_ff[W-1], py_ff} - {prev_y_ff[W-1], prev_y_ff};
      d_in        = {rd_x_ff[W-1], rd_x_ff} - {prev_x_ff[W-1], prev_x_ff};
      bbox_in     = ((prev_x_ff <= px_ff && px_ff <= rd_x_ff) ||
                     (rd_x_ff <= px_ff && px_ff <= prev_x_ff)) &&
                    ((prev_y_ff <= py_ff && py_ff <= rd_y_ff) ||
                     (rd_y_ff <= py_ff && py_ff <= prev_y_ff));
      straddle_in = (prev_x_ff > px_ff) != (rd_x_ff > px_ff);
      dxpos_in    = rd_x_ff > prev_x_ff;
   end

   assign p1_in = PW'(a_ff) * PW'(b_ff);
   assign p2_in = PW'(c_ff) * PW'(d_ff);

   assign cross_diff = {p1_ff[PW-1], p1_ff} - {p2_ff[PW-1], p2_ff};
   assign cross_zero = (cross_diff == '0);
   assign cross_pos  = !cross_diff[DW-1] && !cross_zero;
   assign hit_on     = m_vld_ff && cross_zero && m_bbox_ff;
   assign hit_cross  = m_vld_ff && m_straddle_ff &&
                       (m_dxpos_ff ? cross_pos : cross_diff[DW-1]);

   // datapath payload
   always_ff @(posedge clock) begin
      if (req_fire && req_op == OP_QUERY) begin
         px_ff <= req_coord_x[W-1:0];
         py_ff <= req_coord_y[W-1:0];
      end
      if (rd_vld_ff) begin
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
      end
      a_ff          <= a_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      d_ff          <= d_in;
      bbox_ff       <= bbox_in;
      straddle_ff   <= straddle_in;
      dxpos_ff      <= dxpos_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      m_bbox_ff     <= bbox_ff;
      m_straddle_ff <= straddle_ff;
      m_dxpos_ff    <= dxpos_ff;
   end

   // sequencer, pipeline valids and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= COUNT_WIDTH'(COUNT_RESET);
         n_ff          <= CW'(MIN_VERTICES);
         cnt_ff        <= '0;
         iss_done_ff   <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rd_first_ff   <= 1'b0;
         e_vld_ff      <= 1'b0;
         m_vld_ff      <= 1'b0;
         on_ff         <= 1'b0;
         par_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_inside_ff <= 1'b0;
         rsp_on_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            count_ff <= csr_vertex_count;
         end
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         rd_vld_ff   <= issue;
         rd_first_ff <= issue && (cnt_ff == '0);
         e_vld_ff    <= rd_vld_ff && !rd_first_ff;
         m_vld_ff    <= e_vld_ff;
         if (hit_on) begin
            on_ff <= 1'b1;
         end
         if (hit_cross) begin
            par_ff <= !par_ff;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_op == OP_QUERY) begin
                  n_ff        <= n_in;
                  cnt_ff      <= '0;
                  iss_done_ff <= 1'b0;
                  on_ff       <= 1'b0;
                  par_ff      <= 1'b0;
                  state_ff    <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (issue) begin
                  if (cnt_ff == n_ff) begin
                     iss_done_ff <= 1'b1;
                  end else begin
                     cnt_ff <= cnt_ff + CW'(1);
                  end
               end
               if (iss_done_ff && !rd_vld_ff && !e_vld_ff && !m_vld_ff) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_inside_ff <= on_ff || par_ff;
                  rsp_on_ff     <= on_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Point-in-polygon test unit testbench
// Loads polygons into the vertex table and queries points against them. Queries
// are predicted with exact wide-integer cross products and each response beat
// is checked in order. The run covers a directed triangle set, then random
// polygons (small, medium, full-range and extreme coordinates) under several
// vertex counts, with random idling on both sides and one long response stall.
// -----------------------------------------------------------------------------
module tb;
   import pipt_pkg::*;

   localparam int MAX_VERTICES  = 64;
   localparam int ITEM_TARGET   = 1500;
   localparam int IDLE_PERCENT  = 34;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = MAX_VERTICES + 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_LIMIT  = 10;
   localparam int COORD_MIN     = int'(32'h8000_0000);
   localparam int COORD_MAX     = 2147483647;

   typedef struct {
      op_type                        op;
      logic [INDEX_WIDTH-1:0]        slot;
      logic signed [FIELD_WIDTH-1:0] x;
      logic signed [FIELD_WIDTH-1:0] y;
   } beat_type;

   typedef struct {
      logic in_poly;
      logic on_edge;
   } verdict_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_op = OP_LOAD;
   logic [INDEX_WIDTH-1:0]        req_vertex_index = '0;
   logic signed [FIELD_WIDTH-1:0] req_coord_x = '0;
   logic signed [FIELD_WIDTH-1:0] req_coord_y = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_inside_res;
   logic                          rsp_on_boundary;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [COUNT_WIDTH-1:0]        csr_vertex_count = COUNT_WIDTH'(COUNT_RESET);

   beat_type    pending_beats[$];
   verdict_type expected_verdicts[$];
   beat_type    next_beat;

   logic signed [FIELD_WIDTH-1:0] vertex_x_shadow [MAX_VERTICES];
   logic signed [FIELD_WIDTH-1:0] vertex_y_shadow [MAX_VERTICES];
   logic [COUNT_WIDTH-1:0]        vertex_limit = COUNT_WIDTH'(COUNT_RESET);

   int   poly_x [MAX_VERTICES];
   int   poly_y [MAX_VERTICES];
   int   beats_queued = 0;
   int   mismatches = 0;
   int   cycle_count = 0;
   int   hold_count = 0;
   logic req_taken = 1'b0;
   logic calm = 1'b0;
   logic stall_rsp = 1'b0;

   point_in_polygon_test_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_on_boundary  (rsp_on_boundary),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_vertex_count (csr_vertex_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int vertices_in_use(input logic [COUNT_WIDTH-1:0] count);
      if (count < MIN_VERTICES) return MIN_VERTICES;
      if (count > MAX_VERTICES) return MAX_VERTICES;
      return int'(count);
   endfunction

   function automatic logic signed [71:0] cross_term(input logic signed [71:0] a, b, c, d);
      return a * b - c * d;
   endfunction

   function automatic verdict_type judge_point(input logic signed [FIELD_WIDTH-1:0] qx, qy);
      logic signed [71:0] px, py, x1, y1, x2, y2, dx, dy, side;
      int          n;
      int          j;
      int          crossings;
      verdict_type v;
      n = vertices_in_use(vertex_limit);
      px = qx;
      py = qy;
      crossings = 0;
      for (int i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         x1 = vertex_x_shadow[i];
         y1 = vertex_y_shadow[i];
         x2 = vertex_x_shadow[j];
         y2 = vertex_y_shadow[j];
         dx = x2 - x1;
         dy = y2 - y1;
         if (cross_term(px - x1, dy, py - y1, dx) == 0 &&
             ((x1 <= px && px <= x2) || (x2 <= px && px <= x1)) &&
             ((y1 <= py && py <= y2) || (y2 <= py && py <= y1))) begin
            v.in_poly = 1'b1;
            v.on_edge = 1'b1;
            return v;
         end
         if ((x1 > px) != (x2 > px)) begin
            side = cross_term(dy, px - x1, py - y1, dx);
            if (dx > 0 ? side > 0 : side < 0) crossings++;
         end
      end
      v.in_poly = crossings[0];
      v.on_edge = 1'b0;
      return v;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_beats.size() != 0 &&
             (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
            next_beat = pending_beats.pop_front();
            req_op           <= next_beat.op;
            req_vertex_index <= next_beat.slot;
            req_coord_x      <= next_beat.x;
            req_coord_y      <= next_beat.y;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_rsp && hold_count < HOLD_CYCLES) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= IDLE_PERCENT;
      end
   end

   // monitor
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         vertex_limit <= COUNT_WIDTH'(COUNT_RESET);
         req_taken    <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) vertex_limit <= csr_vertex_count;
         if (req_valid && req_ready) begin
            if (req_op == OP_LOAD) begin
               vertex_x_shadow[req_vertex_index] <= req_coord_x;
               vertex_y_shadow[req_vertex_index] <= req_coord_y;
            end else begin
               expected_verdicts.push_back(judge_point(req_coord_x, req_coord_y));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected response beat: inside=%0b boundary=%0b",
                           rsp_inside_res, rsp_on_boundary);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_inside_res !== want.in_poly || rsp_on_boundary !== want.on_edge) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= REPORT_LIMIT)
                     $display("mismatch: inside exp %0b got %0b, boundary exp %0b got %0b",
                              want.in_poly, rsp_inside_res, want.on_edge, rsp_on_boundary);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   task automatic queue_load(input int slot, input int x, input int y);
      beat_type b;
      b.op   = OP_LOAD;
      b.slot = INDEX_WIDTH'(slot);
      b.x    = x;
      b.y    = y;
      poly_x[slot] = x;
      poly_y[slot] = y;
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   task automatic queue_query(input int x, input int y);
      beat_type b;
      b.op   = OP_QUERY;
      b.slot = INDEX_WIDTH'($urandom_range(MAX_VERTICES - 1));
      b.x    = x;
      b.y    = y;
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   task automatic write_count(input logic [COUNT_WIDTH-1:0] value);
      @(negedge clock);
      csr_vertex_count <= value;
      csr_valid        <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_beats.size() != 0 || req_valid) @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int make_coord(input int mode);
      case (mode)
         0: return int'($urandom_range(16)) - 8;
         1: return int'($urandom_range(2000)) - 1000;
         2: return int'($urandom);
         default: begin
            case ($urandom_range(4))
               0: return COORD_MIN;
               1: return COORD_MAX;
               2: return 0;
               3: return -1;
               default: return 1;
            endcase
         end
      endcase
   endfunction

   task automatic queue_probe(input int mode, input int n);
      int     i;
      int     j;
      int     pick;
      longint mx;
      longint my;
      pick = $urandom_range(99);
      i = $urandom_range(n - 1);
      j = (i + 1 == n) ? 0 : i + 1;
      if (pick < 30) begin
         queue_query(poly_x[i], poly_y[i]);
      end else if (pick < 50) begin
         mx = longint'(poly_x[i]) + (longint'(poly_x[j]) - longint'(poly_x[i])) / 2;
         my = longint'(poly_y[i]) + (longint'(poly_y[j]) - longint'(poly_y[i])) / 2;
         queue_query(int'(mx), int'(my));
      end else if (pick < 85) begin
         case (mode)
            0: queue_query(int'($urandom_range(20)) - 10, int'($urandom_range(20)) - 10);
            1: queue_query(int'($urandom_range(2200)) - 1100,
                           int'($urandom_range(2200)) - 1100);
            default: queue_query(make_coord(mode), make_coord(mode));
         endcase
      end else begin
         queue_query(int'($urandom), int'($urandom));
      end
   endtask

   initial begin
      int                     fixed_counts[7];
      int                     phase;
      int                     mode;
      int                     n;
      int                     queries;
      int                     pick;
      logic [COUNT_WIDTH-1:0] count_value;

      fixed_counts = '{64, 0, 127, 2, 65, 1, 4};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      queue_load(0, 0, 0);
      queue_load(1, 100, 0);
      queue_load(2, 0, 100);
      queue_query(10, 10);
      queue_query(50, 0);
      queue_query(0, 0);
      queue_query(50, 50);
      queue_query(0, 50);
      queue_query(200, 200);
      queue_query(-1, 0);
      queue_query(60, 60);
      queue_load(0, COORD_MIN, COORD_MIN);
      queue_load(1, COORD_MAX, COORD_MIN);
      queue_load(2, 0, COORD_MAX);
      queue_query(0, 0);
      queue_query(COORD_MIN, COORD_MIN);
      queue_query(COORD_MAX, COORD_MAX);
      queue_query(COORD_MIN, COORD_MAX);
      // repeated vertex
      queue_load(2, COORD_MAX, COORD_MIN);
      queue_query(5, COORD_MIN);
      queue_query(0, 0);
      drain();

      phase = 0;
      while (beats_queued < ITEM_TARGET) begin
         if (phase < 7) begin
            count_value = COUNT_WIDTH'(fixed_counts[phase]);
            mode = phase % 4;
         end else begin
            pick = $urandom_range(99);
            if (pick < 70)      count_value = COUNT_WIDTH'($urandom_range(12, 3));
            else if (pick < 85) count_value = COUNT_WIDTH'($urandom_range(63, 13));
            else if (pick < 92) count_value = COUNT_WIDTH'(MAX_VERTICES);
            else                count_value = COUNT_WIDTH'($urandom_range(127));
            mode = $urandom_range(3);
         end
         write_count(count_value);
         n = vertices_in_use(count_value);
         calm = (phase == 3);
         if (phase == 5) stall_rsp = 1'b1;
         for (int s = 0; s < n; s++) queue_load(s, make_coord(mode), make_coord(mode));
         queries = (n > 16) ? 12 : 40;
         for (int q = 0; q < queries; q++) begin
            if ($urandom_range(99) < 15)
               queue_load($urandom_range(MAX_VERTICES - 1), make_coord(mode), make_coord(mode));
            else
               queue_probe(mode, n);
         end
         drain();
         phase++;
      end
      calm = 1'b0;

      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/pipt_pkg.sv
src/point_in_polygon_test_unit.sv
sim/tb.sv
